// ===== rtl/core/ekq_pkg.sv =====
// Shared types and constants for the encoder key event queue.
package ekq_pkg;

    localparam int unsigned POS_W     = 16;
    localparam int unsigned ACC_W     = 18;
    localparam int unsigned KEY_W     = 3;
    localparam int unsigned SENS_W    = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 7;

    localparam logic [KEY_W-1:0] KEY_NONE       = 3'd0;
    localparam logic [KEY_W-1:0] KEY_UP         = 3'd1;
    localparam logic [KEY_W-1:0] KEY_DOWN       = 3'd2;
    localparam logic [KEY_W-1:0] KEY_OK         = 3'd3;
    localparam logic [KEY_W-1:0] KEY_OK_RELEASE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_REVERSED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_STEP    = 2'd2;

    localparam logic [SENS_W-1:0] SENS_RESET = 7'd4;

    typedef struct packed {
        logic                    enc;
        logic signed [POS_W-1:0] delta;
        logic                    push_ok;
        logic                    push_up;
        logic                    push_down;
        logic                    push_rel;
    } t_cmd;

endpackage

// ===== rtl/core/ekq_front.sv =====
// Front end: accept polls, detect edges and count change, emit commands.
module ekq_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_button_mode,
    input  logic                      i_valid,
    input  logic [ekq_pkg::POS_W-1:0] i_encoder_position,
    input  logic                      i_ok_level,
    input  logic                      i_up_level,
    input  logic                      i_down_level,
    input  logic                      i_full,
    output logic                      o_wr,
    output ekq_pkg::t_cmd             o_cmd
);

    logic [ekq_pkg::POS_W-1:0] r_last_pos;
    logic [2:0]                r_prev_levels;
    logic [ekq_pkg::POS_W-1:0] w_diff;

    assign o_wr   = i_valid && !i_full;
    assign w_diff = r_last_pos - i_encoder_position;

    always_comb begin
        o_cmd.enc   = !i_button_mode;
        o_cmd.delta = signed'(w_diff);
        o_cmd.push_ok = r_prev_levels[0] && !i_ok_level;
        if (i_button_mode) begin
            o_cmd.push_up   = r_prev_levels[1] && !i_up_level;
            o_cmd.push_down = r_prev_levels[2] && !i_down_level;
            o_cmd.push_rel  = 1'b0;
        end else begin
            o_cmd.push_up   = 1'b0;
            o_cmd.push_down = 1'b0;
            o_cmd.push_rel  = !r_prev_levels[0] && i_ok_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos    <= '0;
            r_prev_levels <= 3'b111;
        end else if (o_wr) begin
            r_prev_levels <= {i_down_level, i_up_level, i_ok_level};
            if (!i_button_mode) begin
                r_last_pos <= i_encoder_position;
            end
        end
    end

endmodule

// ===== rtl/core/ekq_cmd_queue.sv =====
// Two-entry command queue between front end and back end.
module ekq_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  ekq_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output ekq_pkg::t_cmd o_cmd,
    input  logic          i_rd
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ekq_pkg::t_cmd    r_mem [DEPTH];
    logic             r_wp;
    logic             r_rp;
    logic [CNT_W-1:0] r_count;
    logic             w_do_wr;
    logic             w_do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_do_wr) begin
                r_wp <= !r_wp;
            end
            if (w_do_rd) begin
                r_rp <= !r_rp;
            end
            if (w_do_wr && !w_do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_rd && !w_do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/ekq_back.sv =====
// Back end: step accumulator, key ring and output register.
module ekq_back #(
    parameter int unsigned RING_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_direction_reversed,
    input  logic [ekq_pkg::SENS_W-1:0] i_counts_per_step,
    input  logic                       i_cmd_valid,
    input  ekq_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_rd,
    output logic                       o_out_valid,
    output logic [ekq_pkg::KEY_W-1:0]  o_key_code,
    input  logic                       i_out_stall
);

    localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_POP
    } t_state;

    t_state                          r_state;
    logic signed [ekq_pkg::ACC_W-1:0] r_acc;
    logic                            r_enc;
    logic                            r_push_ok;
    logic                            r_push_up;
    logic                            r_push_down;
    logic                            r_push_rel;
    logic [PTR_W-1:0]                r_wp;
    logic [PTR_W-1:0]                r_rp;
    logic [ekq_pkg::KEY_W-1:0]       r_ring [RING_DEPTH];
    logic                            r_out_valid;
    logic [ekq_pkg::KEY_W-1:0]       r_out_key;

    logic [ekq_pkg::SENS_W-1:0]       w_sens7;
    logic signed [ekq_pkg::ACC_W-1:0] w_sens;
    logic signed [ekq_pkg::ACC_W-1:0] w_acc_plus;
    logic signed [ekq_pkg::ACC_W-1:0] w_acc_minus;
    logic signed [ekq_pkg::ACC_W-1:0] w_delta_ext;
    logic                             w_neg_step;
    logic                             w_pos_step;
    logic                             w_push;
    logic [ekq_pkg::KEY_W-1:0]        w_key;
    logic [PTR_W-1:0]                 w_wp_next;
    logic [PTR_W-1:0]                 w_rp_next;
    logic                             w_out_free;

    assign w_sens7     = (i_counts_per_step == '0) ? ekq_pkg::SENS_W'(1) : i_counts_per_step;
    assign w_sens      = signed'({(ekq_pkg::ACC_W - ekq_pkg::SENS_W)'(0), w_sens7});
    assign w_acc_plus  = r_acc + w_sens;
    assign w_acc_minus = r_acc - w_sens;
    assign w_delta_ext = ekq_pkg::ACC_W'(i_cmd.delta);
    assign w_neg_step  = r_enc && (w_acc_plus <= 0);
    assign w_pos_step  = r_enc && (w_acc_minus >= 0);
    assign w_wp_next   = (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
    assign w_rp_next   = (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cmd_rd    = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_key_code  = r_out_key;

    always_comb begin
        w_push = 1'b1;
        if (w_neg_step) begin
            w_key = i_direction_reversed ? ekq_pkg::KEY_DOWN : ekq_pkg::KEY_UP;
        end else if (w_pos_step) begin
            w_key = i_direction_reversed ? ekq_pkg::KEY_UP : ekq_pkg::KEY_DOWN;
        end else if (r_push_ok) begin
            w_key = ekq_pkg::KEY_OK;
        end else if (r_push_up) begin
            w_key = ekq_pkg::KEY_UP;
        end else if (r_push_down) begin
            w_key = ekq_pkg::KEY_DOWN;
        end else if (r_push_rel) begin
            w_key = ekq_pkg::KEY_OK_RELEASE;
        end else begin
            w_key  = ekq_pkg::KEY_NONE;
            w_push = 1'b0;
        end
        if (r_state != S_STEP) begin
            w_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ring[r_wp] <= w_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_enc       <= 1'b0;
            r_push_ok   <= 1'b0;
            r_push_up   <= 1'b0;
            r_push_down <= 1'b0;
            r_push_rel  <= 1'b0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_POP && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_push) begin
                r_wp <= w_wp_next;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.enc) begin
                            r_acc <= r_acc + w_delta_ext;
                        end
                        r_enc       <= i_cmd.enc;
                        r_push_ok   <= i_cmd.push_ok;
                        r_push_up   <= i_cmd.push_up;
                        r_push_down <= i_cmd.push_down;
                        r_push_rel  <= i_cmd.push_rel;
                        r_state     <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (w_neg_step) begin
                        r_acc <= w_acc_plus;
                    end else if (w_pos_step) begin
                        r_acc <= w_acc_minus;
                    end else if (r_push_ok) begin
                        r_push_ok <= 1'b0;
                    end else if (r_push_up) begin
                        r_push_up <= 1'b0;
                    end else if (r_push_down) begin
                        r_push_down <= 1'b0;
                    end else if (r_push_rel) begin
                        r_push_rel <= 1'b0;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (w_out_free) begin
                        if (r_wp != r_rp) begin
                            r_out_key <= r_ring[r_rp];
                            r_rp      <= w_rp_next;
                        end else begin
                            r_out_key <= ekq_pkg::KEY_NONE;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/encoder_key_event_queue.sv =====
// Top level of the encoder key event queue.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one poll per request: the
//   encoder counter and three debounced active-low button levels.
//   Output channel (o_out_valid / i_out_stall) returns one key code per poll,
//   KEY_NONE when the key ring is empty.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) select button
//   or encoder mode, rotation direction and counts per step.
// Dataflow:
//   A poll passes the front end into a two-entry command queue, then the
//   back end queues its keys into the ring one per cycle and pops one key.
//   With an idle back end the key code reaches the output register after
//   the command queue and the back end's IDLE, STEP and POP states; the back
//   end reads no new poll until it has popped the key of the last one.
// Reset: clears pointers, accumulator, last position and button history;
//   the ring contents are not cleared. counts_per_step resets to 4.
// Stall: a stalled result holds in the output register; the back end waits
//   to pop and the command queue absorbs up to two further polls.
module encoder_key_event_queue #(
    parameter int unsigned RING_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ekq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ekq_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ekq_pkg::POS_W-1:0]     i_encoder_position,
    input  logic                          i_ok_level,
    input  logic                          i_up_level,
    input  logic                          i_down_level,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ekq_pkg::KEY_W-1:0]     o_key_code
);

    logic                       r_button_mode;
    logic                       r_direction_reversed;
    logic [ekq_pkg::SENS_W-1:0] r_counts_per_step;

    logic          w_q_wr;
    logic          w_q_full;
    logic          w_q_valid;
    logic          w_q_rd;
    ekq_pkg::t_cmd w_front_cmd;
    ekq_pkg::t_cmd w_back_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_mode        <= 1'b0;
            r_direction_reversed <= 1'b0;
            r_counts_per_step    <= ekq_pkg::SENS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ekq_pkg::CFG_BUTTON_MODE: begin
                    r_button_mode <= i_cfg_data[0];
                end
                ekq_pkg::CFG_DIRECTION_REVERSED: begin
                    r_direction_reversed <= i_cfg_data[0];
                end
                ekq_pkg::CFG_COUNTS_PER_STEP: begin
                    r_counts_per_step <= i_cfg_data[ekq_pkg::SENS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = w_q_full;

    ekq_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_button_mode      (r_button_mode),
        .i_valid            (i_in_valid),
        .i_encoder_position (i_encoder_position),
        .i_ok_level         (i_ok_level),
        .i_up_level         (i_up_level),
        .i_down_level       (i_down_level),
        .i_full             (w_q_full),
        .o_wr               (w_q_wr),
        .o_cmd              (w_front_cmd)
    );

    ekq_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_back_cmd),
        .i_rd    (w_q_rd)
    );

    ekq_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_direction_reversed (r_direction_reversed),
        .i_counts_per_step    (r_counts_per_step),
        .i_cmd_valid          (w_q_valid),
        .i_cmd                (w_back_cmd),
        .o_cmd_rd             (w_q_rd),
        .o_out_valid          (o_out_valid),
        .o_key_code           (o_key_code),
        .i_out_stall          (i_out_stall)
    );

`ifndef SYNTHESIS
    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_wr && w_q_full))
        else $error("command queue written while full");

    a_no_queue_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_rd |-> w_q_valid)
        else $error("command queue read while empty");

    a_accept_matches_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) == w_q_wr)
        else $error("accepted request not written to command queue");

    a_key_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && $rose(o_out_valid)) |-> (o_key_code <= ekq_pkg::KEY_OK_RELEASE))
        else $error("illegal key code");
`endif

endmodule
